// ===== rtl/fbecho_pkg.sv =====
// Shared package of the feedback echo delay: register indexes, reset values,
// fixed-point constants and the command/status structs.
// No dependencies.
`default_nettype none

package fbecho_pkg;

  // Default sizes, handed down through the top-level parameters.
  localparam int unsigned STORE_DEPTH_DEF = 131072;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  // Configuration port layout.
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 18;
  localparam int unsigned DELAY_BITS     = 18;
  localparam int unsigned GAIN_BITS      = 16;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WET   = 2'd2;

  // Register reset values.
  localparam logic [DELAY_BITS-1:0] DELAY_RESET = 18'd88200;
  localparam logic [GAIN_BITS-1:0]  DECAY_RESET = 16'd16384;
  localparam logic [GAIN_BITS-1:0]  WET_RESET   = 16'd32768;

  // Q1.15 unity gain, rounding offset and shift.
  localparam logic [GAIN_BITS-1:0] GAIN_ONE  = 16'd32768;
  localparam int unsigned          Q15_HALF  = 16384;
  localparam int unsigned          Q15_SHIFT = 15;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // capture the sample, issue the store read
    logic decay;   // scale the stored value by the decay gain
    logic wet;     // scale by the wet level, write the store back
    logic finish;  // form the mix and load the output register
  } fbecho_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a new result this cycle
  } fbecho_status_t;

endpackage

`default_nettype wire

// ===== rtl/fbecho_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module fbecho_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/fbecho_ctrl.sv =====
// Controller of the feedback echo delay: sequences one sample through the
// datapath in four steps. Depends on fbecho_pkg.
`default_nettype none

module fbecho_ctrl
  import fbecho_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire fbecho_status_t status_i,
  output fbecho_cmd_t         cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DECAY = 2'd1;
  localparam logic [1:0] ST_WET   = 2'd2;
  localparam logic [1:0] ST_MIX   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_DECAY;
        end
      end
      ST_DECAY: begin
        cmd_o.decay = 1'b1;
        state_d     = ST_WET;
      end
      ST_WET: begin
        cmd_o.wet = 1'b1;
        state_d   = ST_MIX;
      end
      ST_MIX: begin
        // Hold the finished sum until the output register has room.
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fbecho_dp.sv =====
// Datapath of the feedback echo delay: configuration registers, delay store,
// write pointer, fill mark, the two gain multipliers and the output register.
// Depends on fbecho_pkg and fbecho_ram.
`default_nettype none

module fbecho_dp
  import fbecho_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire fbecho_cmd_t               cmd_i,
  output fbecho_status_t                 status_o,
  input  wire logic                      cfg_valid_i,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  input  wire logic [SAMPLE_BITS-1:0]    dry_in_i,
  input  wire logic                      out_ready_i,
  output logic                           out_valid_o,
  output logic      [SAMPLE_BITS-1:0]    mix_out_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned PW = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int unsigned SW = SAMPLE_BITS + 1;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration registers.
  logic [DELAY_BITS-1:0] delay_samples_q;
  logic [GAIN_BITS-1:0]  decay_gain_q;
  logic [GAIN_BITS-1:0]  wet_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_samples_q <= DELAY_RESET;
      decay_gain_q    <= DECAY_RESET;
      wet_level_q     <= WET_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DELAY: delay_samples_q <= cfg_data_i[DELAY_BITS-1:0];
        REG_DECAY: decay_gain_q    <= cfg_data_i[GAIN_BITS-1:0];
        REG_WET:   wet_level_q     <= cfg_data_i[GAIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective length and clamped gains.
  logic [LW-1:0]        len;
  logic                 bypass;
  logic [GAIN_BITS-1:0] dg;
  logic [GAIN_BITS-1:0] wl;

  always_comb begin
    if (32'(delay_samples_q) > 32'(STORE_DEPTH)) begin
      len = LW'(STORE_DEPTH);
    end else begin
      len = LW'(delay_samples_q);
    end
  end

  assign bypass = (len == '0);
  assign dg     = (decay_gain_q > GAIN_ONE) ? GAIN_ONE : decay_gain_q;
  assign wl     = (wet_level_q > GAIN_ONE) ? GAIN_ONE : wet_level_q;

  // Pointer and fill mark. Every address below the fill mark has been written;
  // the pointer only steps by one or restarts at zero, so written entries always
  // form a prefix of the store.
  logic [AW-1:0] pos_q;
  logic [AW-1:0] pos_eff;
  logic [AW-1:0] pos_next;
  logic [LW-1:0] pos_inc;
  logic [LW-1:0] fill_q;
  logic          hit_q;
  logic          bypass_q;

  assign pos_eff  = ({1'b0, pos_q} >= len) ? '0 : pos_q;
  assign pos_inc  = {1'b0, pos_q} + LW'(1);
  assign pos_next = (pos_inc >= len) ? '0 : pos_inc[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      fill_q   <= '0;
      hit_q    <= 1'b0;
      bypass_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        bypass_q <= bypass;
        hit_q    <= ({1'b0, pos_eff} < fill_q);
        if (!bypass) begin
          pos_q <= pos_eff;
        end
      end
      if (cmd_i.wet && !bypass_q) begin
        pos_q <= pos_next;
        if ({1'b0, pos_q} >= fill_q) begin
          fill_q <= pos_inc;
        end
      end
    end
  end

  // Delay store.
  logic                          store_we;
  logic signed [SAMPLE_BITS-1:0] store_wdata;
  logic        [SAMPLE_BITS-1:0] store_rdata;

  fbecho_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (pos_q),
    .wdata_i (store_wdata),
    .re_i    (cmd_i.start),
    .raddr_i (pos_eff),
    .rdata_o (store_rdata)
  );

  // Sample registers.
  logic signed [SAMPLE_BITS-1:0] dry_q;
  logic signed [SAMPLE_BITS-1:0] decayed_q;
  logic signed [SAMPLE_BITS-1:0] wet_q;

  // Decay multiply; an entry beyond the fill mark reads as zero.
  logic signed [SAMPLE_BITS-1:0] stored;
  logic signed [PW-1:0]          decay_prod;
  logic signed [PW-1:0]          decay_sum;
  logic signed [PW-1:0]          decay_rnd;

  assign stored     = hit_q ? $signed(store_rdata) : '0;
  assign decay_prod = stored * $signed({1'b0, dg});
  assign decay_sum  = decay_prod + $signed(PW'(Q15_HALF));
  assign decay_rnd  = decay_sum >>> Q15_SHIFT;

  // Wet multiply.
  logic signed [PW-1:0] wet_prod;
  logic signed [PW-1:0] wet_sum;
  logic signed [PW-1:0] wet_rnd;

  assign wet_prod = decayed_q * $signed({1'b0, wl});
  assign wet_sum  = wet_prod + $signed(PW'(Q15_HALF));
  assign wet_rnd  = wet_sum >>> Q15_SHIFT;

  // Write-back and mix sums, each saturated to the sample range.
  logic signed [SW-1:0] fb_sum;
  logic signed [SW-1:0] mix_sum;
  logic signed [SAMPLE_BITS-1:0] mix_sat;

  assign fb_sum  = SW'(decayed_q) + SW'(dry_q);
  assign mix_sum = SW'(wet_q) + SW'(dry_q);

  always_comb begin
    if (fb_sum[SW-1] != fb_sum[SW-2]) begin
      store_wdata = fb_sum[SW-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      store_wdata = fb_sum[SAMPLE_BITS-1:0];
    end
    if (mix_sum[SW-1] != mix_sum[SW-2]) begin
      mix_sat = mix_sum[SW-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      mix_sat = mix_sum[SAMPLE_BITS-1:0];
    end
  end

  assign store_we = cmd_i.wet && !bypass_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dry_q <= $signed(dry_in_i);
    end
    if (cmd_i.decay) begin
      decayed_q <= decay_rnd[SAMPLE_BITS-1:0];
    end
    if (cmd_i.wet) begin
      wet_q <= bypass_q ? '0 : wet_rnd[SAMPLE_BITS-1:0];
    end
  end

  // Output register.
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= mix_sat;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign mix_out_o         = out_q;

endmodule

`default_nettype wire

// ===== rtl/feedback_echo_delay_top.sv =====
// Top level of the feedback echo delay: controller plus datapath.
// Depends on fbecho_pkg, fbecho_ctrl, fbecho_dp and fbecho_ram.
//
// Usage. Samples enter on the in channel (in_valid_i, in_ready_o, dry_in_i),
// one signed sample per transaction, and leave on the out channel (out_valid_o,
// out_ready_i, mix_out_o), exactly one mixed sample per input transaction and
// in the same order. The cfg channel writes one register per transaction:
// index 0 is the delay in samples, 1 the decay gain, 2 the wet level (both
// Q1.15); other indexes are ignored. The cfg channel is always ready and is
// meant to be written only while no sample is in flight.
// Sequence: the transaction edge issues the store read; the controller's steps
// then do the decay multiply, the wet multiply with store write-back and the
// final saturating sum, which is loaded into the output register. No new
// sample is accepted until the previous one has been loaded there, set by
// the controller's four-step sequence around the single store port and the
// two chained multipliers.
// Reset: the registers return to a delay of 88200, decay 0.5 and wet level
// 1.0, the write pointer to zero, and the store reads as all zero. No clearing
// pass is run: a fill mark tracks which store entries have been written, and
// unwritten entries read as zero, so samples are accepted right after reset.
// Stalls: when the receiver holds out_ready_i low, the finished result waits
// in the output register while the next sample is accepted and processed; the
// controller then holds that one in its last step until the register frees.
`default_nettype none

module feedback_echo_delay_top
  import fbecho_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Configuration channel.
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  // Input sample channel.
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]    dry_in_i,
  // Output sample channel.
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [SAMPLE_BITS-1:0]    mix_out_o
);

  fbecho_cmd_t    cmd;
  fbecho_status_t status;

  // Register writes are always accepted and are registered at the edge that ends the cycle they are presented in.
  assign cfg_ready_o = 1'b1;

  // The controller steps each accepted sample through the datapath.
  fbecho_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the registers, the delay store and the arithmetic.
  fbecho_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .dry_in_i    (dry_in_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .mix_out_o   (mix_out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/fbecho_checker.sv =====
// Port-level checker of the feedback echo delay and its bind to the top level.
// Depends on fbecho_pkg.
`default_nettype none

module fbecho_checker
  import fbecho_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      cfg_valid_i,
  input wire logic                      cfg_ready_o,
  input wire logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input wire logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [SAMPLE_BITS-1:0]    mix_out_o
);

  logic in_acc;
  logic out_acc;
  logic [1:0] pending_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Samples accepted whose results have not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mix_out_o))
    else $error("stalled result changed or dropped");

  // An accepted sample keeps the block busy for its three working steps.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("sample accepted during processing");

  // A result is only shown for a sample that was accepted.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("result without a pending sample");

  // At most one sample in work and one result waiting.
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3 && (!in_ready_o || pending_q != 2'd2))
    else $error("too many samples in flight");

  // The configuration channel never stalls and carries a defined write.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o && !$isunknown({cfg_index_i, cfg_data_i}))
    else $error("configuration write stalled or undefined");

endmodule

bind feedback_echo_delay_top fbecho_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (.*);

`default_nettype wire

// ===== tb/echo_mix_checker.sv =====
// Checker for the feedback echo delay: watches the cfg, in and out channels,
// keeps its own copy of the echo store, and compares every mixed sample.
// Depends on fbecho_pkg for register indexes, reset values and Q1.15 constants.
`timescale 1ns / 1ps

module echo_mix_checker
  import fbecho_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  input  wire logic                      cfg_ready_i,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_ready_i,
  input  wire logic [SAMPLE_BITS_DEF-1:0] dry_in_i,
  input  wire logic                      out_valid_i,
  input  wire logic                      out_ready_i,
  input  wire logic [SAMPLE_BITS_DEF-1:0] mix_out_i,
  output int                             mixes_seen_o,
  output int                             fail_count_o
);

  localparam int SB = SAMPLE_BITS_DEF;
  localparam longint SAMPLE_MAX = (64'sd1 <<< (SB - 1)) - 64'sd1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 64'sd1;

  typedef logic signed [SB-1:0] sample_t;

  sample_t                            echo_line [STORE_DEPTH_DEF];
  logic [DELAY_BITS-1:0]              delay_len;
  logic [GAIN_BITS-1:0]               decay_q15;
  logic [GAIN_BITS-1:0]               wet_q15;
  logic [$clog2(STORE_DEPTH_DEF)-1:0] tap_pos;
  sample_t                            expected_mix_q [$];
  sample_t                            want_mix;

  function automatic longint clamp_sample(input longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  // Round to nearest with ties toward plus infinity, as an arithmetic shift.
  function automatic longint q15_scale(input longint s, input longint g);
    return (s * g + longint'(Q15_HALF)) >>> Q15_SHIFT;
  endfunction

  // Advances the echo store by one sample and returns the mix it produces.
  function automatic sample_t predict_mix(input sample_t dry);
    int unsigned len;
    longint      dg;
    longint      wl;
    longint      decayed;
    longint      mixed;
    len = (delay_len > STORE_DEPTH_DEF) ? STORE_DEPTH_DEF : delay_len;
    dg  = (decay_q15 > GAIN_ONE) ? GAIN_ONE : decay_q15;
    wl  = (wet_q15 > GAIN_ONE) ? GAIN_ONE : wet_q15;
    if (len == 0) return dry;
    // A shortened delay can leave the pointer past the end.
    if (tap_pos >= len) tap_pos = '0;
    decayed = q15_scale(longint'(echo_line[tap_pos]), dg);
    mixed   = clamp_sample(longint'(dry) + q15_scale(decayed, wl));
    echo_line[tap_pos] = sample_t'(clamp_sample(decayed + longint'(dry)));
    tap_pos = tap_pos + 1'b1;
    if (tap_pos >= len) tap_pos = '0;
    return sample_t'(mixed);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (echo_line[i]) echo_line[i] = '0;
      delay_len = DELAY_RESET;
      decay_q15 = DECAY_RESET;
      wet_q15   = WET_RESET;
      tap_pos   = '0;
      expected_mix_q.delete();
      mixes_seen_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DELAY: delay_len = cfg_data_i[DELAY_BITS-1:0];
          REG_DECAY: decay_q15 = cfg_data_i[GAIN_BITS-1:0];
          REG_WET:   wet_q15   = cfg_data_i[GAIN_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_mix_q.push_back(predict_mix(sample_t'(dry_in_i)));
      end
      if (out_valid_i && out_ready_i) begin
        mixes_seen_o <= mixes_seen_o + 1;
        if (expected_mix_q.size() == 0) begin
          $error("mix_out: result with no sample waiting, actual %0d", $signed(mix_out_i));
          fail_count_o <= fail_count_o + 1;
        end else begin
          want_mix = expected_mix_q.pop_front();
          if (mix_out_i !== want_mix) begin
            $error("mix_out mismatch: expected %0d, actual %0d", want_mix, $signed(mix_out_i));
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the feedback echo delay: clock, reset, stimulus and verdict.
// Depends on fbecho_pkg, feedback_echo_delay_top and echo_mix_checker.
`timescale 1ns / 1ps

module tb_top;
  import fbecho_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int RANDOM_SAMPLES = 1200;

  // Index past the register list; the block must ignore writes to it.
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  localparam logic [SB-1:0] SAMPLE_MAX = {1'b0, {(SB - 1){1'b1}}};
  localparam logic [SB-1:0] SAMPLE_MIN = {1'b1, {(SB - 1){1'b0}}};
  localparam logic [SB-1:0] SAMPLE_NEG_ONE = {SB{1'b1}};

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic [SB-1:0]             dry_in_i = '0;
  logic                      out_ready_i = 1'b0;
  wire logic                 cfg_ready_o;
  wire logic                 in_ready_o;
  wire logic                 out_valid_o;
  wire logic [SB-1:0]        mix_out_o;

  int   mixes_seen;
  int   fail_count;
  int   samples_sent = 0;
  int   random_sent = 0;
  int   ready_stall = 0;
  logic steady_flow = 1'b0;

  feedback_echo_delay_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .dry_in_i    (dry_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .mix_out_o   (mix_out_o)
  );

  // The checker sees the same channels as the block and keeps the verdict data.
  echo_mix_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .dry_in_i     (dry_in_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mix_out_i    (mix_out_o),
    .mixes_seen_o (mixes_seen),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Idle length shared by both sides: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Gains cover zero, unity, just below unity, and values above unity,
  // including data with the bits above the register width set.
  function automatic logic [CFG_DATA_BITS-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_DATA_BITS'(GAIN_ONE);
      2: return CFG_DATA_BITS'($urandom);
      3: return CFG_DATA_BITS'(GAIN_ONE - 1'b1);
      default: return CFG_DATA_BITS'($urandom_range(0, 32768));
    endcase
  endfunction

  // Samples: full-scale extremes, small values of either sign, or any value.
  function automatic logic [SB-1:0] pick_sample();
    logic [SB-1:0] v;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      1: begin
        v = SB'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = SB'($urandom);
    endcase
    return v;
  endfunction

  // The receiver stalls at random. In steady stretches it starts no new stalls.
  always @(posedge clk_i) begin
    if (ready_stall != 0) begin
      ready_stall <= ready_stall - 1;
      out_ready_i <= 1'b0;
    end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
      ready_stall <= idle_len();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // One register write per transaction. Valid stays high across back-to-back
  // writes; the caller lowers it once the group of writes is done.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Offers one sample and waits for its transaction. Valid is only lowered
  // when a gap follows, so consecutive samples can stream without a bubble.
  task automatic send_sample(input logic [SB-1:0] value);
    int gap;
    in_valid_i <= 1'b1;
    dry_in_i   <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    samples_sent++;
    gap = steady_flow ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Every sample gives exactly one mix, so the block is idle once the checker
  // has seen as many mixes as samples were sent. Registers are only written
  // after this.
  task automatic drain_mixes();
    in_valid_i <= 1'b0;
    while (mixes_seen != samples_sent) @(posedge clk_i);
  endtask

  initial begin
    int n;
    // Reset is held low at the start and released once.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: the store reads as zero, so each mix is the dry sample.
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(SB'(1));
    send_sample(SAMPLE_NEG_ONE);
    drain_mixes();

    // A zero delay bypasses the wet path and leaves the store untouched.
    write_reg(REG_DELAY, '0);
    cfg_valid_i <= 1'b0;
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    drain_mixes();

    // Short loop at unity gains so write-back and mix both saturate.
    write_reg(REG_DELAY, CFG_DATA_BITS'(3));
    write_reg(REG_DECAY, CFG_DATA_BITS'(GAIN_ONE));
    write_reg(REG_WET, CFG_DATA_BITS'(GAIN_ONE));
    cfg_valid_i <= 1'b0;
    repeat (4) send_sample(SAMPLE_MAX);
    repeat (3) send_sample(SAMPLE_MIN);
    drain_mixes();

    // Gains above unity must clamp to one.
    write_reg(REG_DECAY, {CFG_DATA_BITS{1'b1}});
    write_reg(REG_WET, CFG_DATA_BITS'(40000));
    cfg_valid_i <= 1'b0;
    repeat (2) send_sample(SAMPLE_MAX);
    drain_mixes();

    // Move the pointer well into a longer delay, then shrink the delay below
    // it so the pointer has to restart at the first entry.
    write_reg(REG_DELAY, CFG_DATA_BITS'(8));
    cfg_valid_i <= 1'b0;
    repeat (5) send_sample(pick_sample());
    drain_mixes();
    write_reg(REG_DELAY, CFG_DATA_BITS'(2));
    cfg_valid_i <= 1'b0;
    repeat (3) send_sample(pick_sample());
    drain_mixes();

    // A delay beyond the store depth saturates; a write past the register
    // list must change nothing.
    write_reg(REG_DELAY, {CFG_DATA_BITS{1'b1}});
    write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
    cfg_valid_i <= 1'b0;
    repeat (2) send_sample(pick_sample());
    drain_mixes();

    // Random phases. Each one drains, picks new settings and streams a burst.
    // Delays are mostly short so the echoes come back within the burst.
    while (random_sent < RANDOM_SAMPLES) begin
      drain_mixes();
      case ($urandom_range(0, 19))
        0: write_reg(REG_DELAY, '0);
        1: write_reg(REG_DELAY, CFG_DATA_BITS'(STORE_DEPTH_DEF));
        2: write_reg(REG_DELAY, {CFG_DATA_BITS{1'b1}});
        3: write_reg(REG_DELAY, CFG_DATA_BITS'($urandom_range(65, 4000)));
        default: write_reg(REG_DELAY, CFG_DATA_BITS'($urandom_range(1, 64)));
      endcase
      write_reg(REG_DECAY, pick_gain());
      write_reg(REG_WET, pick_gain());
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
      cfg_valid_i <= 1'b0;
      // About one phase in four runs with no idling on either side.
      steady_flow <= ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 150);
      repeat (n) begin
        send_sample(pick_sample());
        random_sent++;
      end
    end

    // Wait for every outstanding mix, then keep the clock running in case the
    // block produces anything it should not.
    drain_mixes();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest legal run.
  initial begin
    #15_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
